/* sv/bmhq_pkg.sv */
// bmhq_pkg: transfer types, entry layout, status codes and controller states
// for the binary min-heap queue. No dependencies.
`default_nettype none

package bmhq_pkg;

  localparam int KEY_W   = 16;
  localparam int PAY_W   = 16;
  localparam int DEPTH   = 16;              // slot 0 unused: holds DEPTH-1 entries
  localparam int CNT_W   = $clog2(DEPTH);
  localparam int ENT_W   = KEY_W + PAY_W;

  localparam logic       OP_INSERT = 1'b0;
  localparam logic       OP_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic             op;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } in_item_t;

  typedef struct packed {
    status_t          status;
    logic [KEY_W-1:0] out_key;
    logic [PAY_W-1:0] out_payload;
    logic [CNT_W-1:0] entry_count;
  } out_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SIFT_UP,
    S_REM,
    S_SIFT_DN,
    S_PLACE,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

/* sv/binary_min_heap_queue.sv */
// Binary min-heap queue: an insert sifts up from the new leaf; a remove takes the root,
// moves the last entry there and sifts it down when the root has children; a refused op
// or a first insert goes straight to the result. One heap level per cycle, set by the single write port of the
// store; next input transfer is taken the cycle after the result is loaded, so one item
// is in flight at a time, and an output stall holds it.
// Reset (rst_n low, synchronous): heap empty, no result pending; store not cleared.
`default_nettype none

module binary_min_heap_queue (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire bmhq_pkg::in_item_t in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output bmhq_pkg::out_item_t  out_data
);
  import bmhq_pkg::*;

  localparam logic [CNT_W-1:0] MAX_FILL = CNT_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] ROOT     = CNT_W'(1);

  // Entry store: one write port, two registered read ports.
  entry_t           mem [DEPTH];
  logic [CNT_W-1:0] rd_addr_a, rd_addr_b, wr_addr;
  entry_t           rd_a_r, rd_b_r, wr_data;
  logic             wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_r <= mem[rd_addr_a];
    rd_b_r <= mem[rd_addr_b];
  end

  // Controller state
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;      // hole position of the moving entry
  entry_t           ent_r, ent_nxt;      // the moving entry, held out of the store
  out_item_t        res_r, res_nxt;      // result waiting for the output register
  out_item_t        out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Handshake, insert and sift-down helpers
  logic             accept, out_take;
  logic [CNT_W:0]   cur_left;            // left child of pos_r
  logic             right_ok;
  logic [CNT_W-1:0] best_pos;
  entry_t           best_ent;
  logic [CNT_W-1:0] dpos;                // position to descend from
  logic [CNT_W:0]   d_left;
  logic [CNT_W-1:0] ins_pos;
  entry_t           in_ent;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign in_ent   = '{key: in_data.key, payload: in_data.payload};
  assign ins_pos  = fill_r + CNT_W'(1);

  assign cur_left = {pos_r, 1'b0};
  // right child exists when left+1 <= fill, i.e. left < fill
  assign right_ok = (cur_left < {1'b0, fill_r});
  always_comb begin
    if (right_ok && (rd_b_r.key < rd_a_r.key)) begin
      best_pos = cur_left[CNT_W-1:0] | CNT_W'(1);
      best_ent = rd_b_r;
    end else begin
      best_pos = cur_left[CNT_W-1:0];
      best_ent = rd_a_r;
    end
  end
  assign dpos   = (state_r == S_REM) ? ROOT : best_pos;
  assign d_left = {dpos, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    ent_r <= ent_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    pos_nxt       = pos_r;
    ent_nxt       = ent_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_take;
    rd_addr_a     = ROOT;
    rd_addr_b     = fill_r;
    wr_en         = 1'b0;
    wr_addr       = pos_r;
    wr_data       = ent_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_nxt = '{status: ST_OK, out_key: '0, out_payload: '0, entry_count: fill_r};
          if (in_data.op == OP_INSERT) begin
            if (fill_r == MAX_FILL) begin
              res_nxt.status = ST_FULL;
              state_nxt      = S_DONE;
            end else begin
              fill_nxt              = ins_pos;
              res_nxt.entry_count   = ins_pos;
              pos_nxt               = ins_pos;
              ent_nxt               = in_ent;
              if (ins_pos == ROOT) begin
                // first entry goes straight to the root
                wr_en     = 1'b1;
                wr_addr   = ROOT;
                wr_data   = in_ent;
                state_nxt = S_DONE;
              end else begin
                rd_addr_a = ins_pos >> 1;
                state_nxt = S_SIFT_UP;
              end
            end
          end else begin
            if (fill_r == '0) begin
              res_nxt.status = ST_EMPTY;
              state_nxt      = S_DONE;
            end else begin
              // fetch root and last entry together
              rd_addr_a           = ROOT;
              rd_addr_b           = fill_r;
              fill_nxt            = fill_r - CNT_W'(1);
              res_nxt.entry_count = fill_r - CNT_W'(1);
              state_nxt           = S_REM;
            end
          end
        end
      end

      S_SIFT_UP: begin
        // rd_a_r holds the parent of pos_r
        if (ent_r.key < rd_a_r.key) begin
          wr_en   = 1'b1;
          wr_addr = pos_r;
          wr_data = rd_a_r;
          pos_nxt = pos_r >> 1;
          if ((pos_r >> 1) == ROOT) begin
            state_nxt = S_PLACE;
          end else begin
            rd_addr_a = pos_r >> 2;
          end
        end else begin
          wr_en     = 1'b1;
          state_nxt = S_DONE;
        end
      end

      S_REM: begin
        res_nxt.out_key     = rd_a_r.key;
        res_nxt.out_payload = rd_a_r.payload;
        ent_nxt             = rd_b_r;
        pos_nxt             = ROOT;
        if (fill_r == '0) begin
          state_nxt = S_DONE;
        end else if (d_left > {1'b0, fill_r}) begin
          // root is a leaf: last entry lands there
          wr_en     = 1'b1;
          wr_addr   = ROOT;
          wr_data   = rd_b_r;
          state_nxt = S_DONE;
        end else begin
          rd_addr_a = d_left[CNT_W-1:0];
          rd_addr_b = d_left[CNT_W-1:0] | CNT_W'(1);
          state_nxt = S_SIFT_DN;
        end
      end

      S_SIFT_DN: begin
        // rd_a_r / rd_b_r hold the children of pos_r
        if (best_ent.key < ent_r.key) begin
          wr_en   = 1'b1;
          wr_addr = pos_r;
          wr_data = best_ent;
          pos_nxt = best_pos;
          if (d_left > {1'b0, fill_r}) begin
            state_nxt = S_PLACE;
          end else begin
            rd_addr_a = d_left[CNT_W-1:0];
            rd_addr_b = d_left[CNT_W-1:0] | CNT_W'(1);
          end
        end else begin
          wr_en     = 1'b1;
          state_nxt = S_DONE;
        end
      end

      S_PLACE: begin
        wr_en     = 1'b1;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        // load the output register once it is free or draining
        if (!out_valid_r || !out_stall) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* tb/sv/heap_checker.sv */
`timescale 1ns / 100ps
// heap_checker: watches both channels of the binary min-heap queue, keeps its own
// copy of the heap to work out each result, and compares. Depends on bmhq_pkg.

module heap_checker (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  input  wire                  in_stall,
  input  bmhq_pkg::in_item_t   in_data,
  input  wire                  out_valid,
  input  wire                  out_stall,
  input  bmhq_pkg::out_item_t  out_data,
  output int                   err_count,
  output int                   awaited
);
  import bmhq_pkg::*;

  logic [KEY_W-1:0] slot_key [DEPTH];
  logic [PAY_W-1:0] slot_pay [DEPTH];
  int unsigned      held  = 0;
  int               fails = 0;
  out_item_t        due_q[$];

  initial begin
    err_count = 0;
    awaited   = 0;
  end

  function automatic void exchange(int unsigned a, int unsigned b);
    logic [KEY_W-1:0] k;
    logic [PAY_W-1:0] p;
    k           = slot_key[a];
    p           = slot_pay[a];
    slot_key[a] = slot_key[b];
    slot_pay[a] = slot_pay[b];
    slot_key[b] = k;
    slot_pay[b] = p;
  endfunction

  // One operation on the shadow heap; returns the result it should produce.
  function automatic out_item_t apply_op(in_item_t it);
    out_item_t   r;
    int unsigned pos;
    int unsigned kid;
    r        = '0;
    r.status = ST_OK;
    if (it.op == OP_INSERT) begin
      if (held >= DEPTH - 1) begin
        r.status = ST_FULL;
      end else begin
        held++;
        slot_key[held] = it.key;
        slot_pay[held] = it.payload;
        pos = held;
        // strict compare: a tie stays below its parent
        while (pos > 1 && slot_key[pos] < slot_key[pos / 2]) begin
          exchange(pos, pos / 2);
          pos = pos / 2;
        end
      end
    end else if (held == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.out_key     = slot_key[1];
      r.out_payload = slot_pay[1];
      slot_key[1]   = slot_key[held];
      slot_pay[1]   = slot_pay[held];
      held--;
      pos = 1;
      while (2 * pos <= held) begin
        kid = 2 * pos;
        // left child wins a tie
        if (kid + 1 <= held && slot_key[kid + 1] < slot_key[kid]) kid++;
        if (slot_key[kid] < slot_key[pos]) begin
          exchange(pos, kid);
          pos = kid;
        end else begin
          break;
        end
      end
    end
    r.entry_count = held[CNT_W-1:0];
    return r;
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      held = 0;
      due_q.delete();
    end else begin
      // result first: a result never belongs to an item taken at the same edge
      if (out_valid && !out_stall) begin
        if (due_q.size() == 0) begin
          $display("%0t: result with nothing awaited, expected none, actual %h",
                   $time, out_data);
          fails++;
        end else begin
          want = due_q.pop_front();
          check_field("status", want.status, out_data.status);
          check_field("out_key", want.out_key, out_data.out_key);
          check_field("out_payload", want.out_payload, out_data.out_payload);
          check_field("entry_count", want.entry_count, out_data.entry_count);
        end
      end
      if (in_valid && !in_stall) due_q.push_back(apply_op(in_data));
    end
    err_count <= fails;
    awaited   <= due_q.size();
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// testbench: stimulus, clock, reset and verdict for binary_min_heap_queue.
// Depends on bmhq_pkg, binary_min_heap_queue and heap_checker.

module testbench;
  import bmhq_pkg::*;

  localparam int CYCLE_LIMIT = 200000;  // watchdog limit on run length
  localparam int RAND_ITEMS  = 800;
  localparam int PHASE_LEN   = 100;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_stall = 1'b0;
  wire       in_stall;
  wire       out_valid;
  out_item_t out_data;

  int        err_count;
  int        awaited;
  int        cycles    = 0;
  bit        calm      = 1'b0;   // set for the closing stretch: no idling on either side
  int        gap_pct   = 0;      // chance of an input gap after each transfer

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  binary_min_heap_queue DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  heap_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .err_count (err_count),
    .awaited   (awaited)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result-side back-pressure: stall-free stretches (some long) broken by
  // stall bursts. Each assignment lands on its own edge.
  initial begin
    int unsigned run;
    int unsigned hold;
    forever begin
      run = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 25);
      repeat (run) @(posedge clk);
      if (!calm) begin
        hold = $urandom_range(1, 19);
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic in_item_t ins(logic [KEY_W-1:0] k, logic [PAY_W-1:0] p);
    in_item_t it;
    it.op      = OP_INSERT;
    it.key     = k;
    it.payload = p;
    return it;
  endfunction

  // Key and payload of a remove are don't-care: fill them with noise.
  function automatic in_item_t rem();
    in_item_t it;
    it.op      = OP_REMOVE;
    it.key     = KEY_W'($urandom);
    it.payload = PAY_W'($urandom);
    return it;
  endfunction

  // Keys lean towards a narrow band so ties are common, plus the extremes.
  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return KEY_W'($urandom_range(0, 7));
      default: return KEY_W'($urandom);
    endcase
  endfunction

  // Present one item and hold it until the transfer; then perhaps idle.
  // Called just after a rising edge; valid is only lowered for a real gap.
  task automatic send(in_item_t it);
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  initial begin
    // bias towards insert per phase: sweeps the heap to full and to empty
    int unsigned ins_bias [8] = '{85, 15, 85, 50, 15, 85, 50, 15};
    int unsigned ins_pct;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Remove from an empty heap first.
    gap_pct = 25;
    send(rem());
    // Fill to capacity: extremes of key and payload, and a run of equal keys
    // so that ties arise on both sift-up and sift-down.
    send(ins(16'hFFFF, 16'hFFFF));
    send(ins(16'h0000, 16'h0000));
    send(ins(16'h0007, 16'h0A01));
    send(ins(16'h0007, 16'h0A02));
    send(ins(16'h0007, 16'h0A03));
    send(ins(16'h0007, 16'h0A04));
    send(ins(16'h0003, 16'h5555));
    send(ins(16'hFFFF, 16'hAAAA));
    send(ins(16'h8000, 16'h8000));
    send(ins(16'h0001, 16'h7FFF));
    send(ins(16'h0007, 16'h0A05));
    send(ins(16'h7FFF, 16'h0001));
    send(ins(16'h0002, 16'hFFFE));
    send(ins(16'h0007, 16'h0A06));
    send(ins(16'h0000, 16'hFFFF));
    // heap now full: insert must be refused
    send(ins(16'h0000, 16'h1234));
    repeat (6) send(rem());

    // Random part, in phases of differing insert bias and idling.
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % PHASE_LEN == 0) begin
        ins_pct = ins_bias[i / PHASE_LEN];
        gap_pct = ($urandom_range(0, 3) == 0) ? 0 : 30;
        if (i >= RAND_ITEMS - PHASE_LEN) begin
          calm    = 1'b1;
          gap_pct = 0;
        end
      end
      if ($urandom_range(0, 99) < ins_pct) send(ins(pick_key(), PAY_W'($urandom)));
      else send(rem());
    end
    in_valid <= 1'b0;

    // Drain: let the last transfer be counted, then wait for every awaited
    // result, then a margin past the worst latency for strays.
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
